// ----- rtl/crc8fr_pkg.sv -----
`timescale 1ns / 1ps

package crc8fr_pkg;

    localparam logic [7:0] SYNC_RESET = 8'hAA;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_TOP    = 8'h80;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_INSTR   = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_ACCEPTED  = 2'd1,
        KIND_MISMATCH  = 2'd2,
        KIND_HEARTBEAT = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] instruction;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
    } result_t;

    // crc-8, msb first, one byte per call
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 8'h00)
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- rtl/crc8fr_in_stage.sv -----
`timescale 1ns / 1ps

module crc8fr_in_stage import crc8fr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] link_byte,
    input  logic       step,
    output logic       full,
    output logic [7:0] byte_out
);

    logic       full_reg;
    logic       full_next;
    logic [7:0] byte_reg;

    // a new beat can land when the stage is empty or drains this cycle
    assign in_ready = !full_reg || step;

    always_comb
    begin
        full_next = full_reg;
        if (in_valid && in_ready)
            full_next = 1'b1;
        else if (step)
            full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= link_byte;
    end

    assign full     = full_reg;
    assign byte_out = byte_reg;

endmodule

// ----- rtl/crc8fr_deframer.sv -----
`timescale 1ns / 1ps

module crc8fr_deframer import crc8fr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] byte_in,
    input  logic [7:0] sync_value,
    output logic       res_valid,
    output result_t    res
);

    phase_t     phase_reg, phase_next;
    logic [7:0] instr_reg, instr_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] seen_reg, seen_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] crc_upd;
    logic [7:0] seen_inc;

    assign crc_upd  = crc8_step(crc_reg, byte_in);
    assign seen_inc = seen_reg + 8'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        instr_next       = instr_reg;
        len_next         = len_reg;
        seen_next        = seen_reg;
        crc_next         = crc_reg;
        res_valid        = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.instruction  = instr_reg;
        res.data_byte    = byte_in;
        res.byte_index   = 8'd0;
        res.frame_length = len_reg;
        case (phase_reg)
            PH_INSTR:
            begin
                instr_next = byte_in;
                crc_next   = crc_upd;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                len_next   = byte_in;
                crc_next   = crc_upd;
                seen_next  = 8'd0;
                phase_next = (byte_in != 8'd0) ? PH_PAYLOAD : PH_CRC;
            end
            PH_PAYLOAD:
            begin
                crc_next       = crc_upd;
                res_valid      = 1'b1;
                res.byte_index = seen_reg;
                seen_next      = seen_inc;
                if (seen_inc == len_reg)
                    phase_next = PH_CRC;
            end
            PH_CRC:
            begin
                res_valid = 1'b1;
                if (byte_in != crc_reg)
                    res.kind = KIND_MISMATCH;
                else if (instr_reg == 8'd0 && len_reg == 8'd0)
                    res.kind = KIND_HEARTBEAT;
                else
                    res.kind = KIND_ACCEPTED;
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (byte_in == sync_value)
                begin
                    crc_next   = crc8_step(8'h00, byte_in);
                    phase_next = PH_INSTR;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            instr_reg <= 8'd0;
            len_reg   <= 8'd0;
            seen_reg  <= 8'd0;
            crc_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            instr_reg <= instr_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            crc_reg   <= crc_next;
        end
    end

endmodule

// ----- rtl/crc8fr_out_stage.sv -----
`timescale 1ns / 1ps

module crc8fr_out_stage import crc8fr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    can_load,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// ----- rtl/crc8_frame_receiver_unit.sv -----
`timescale 1ns / 1ps

// Sync/length/CRC-8 frame receiver. One link byte is taken per beat and the
// block sustains one byte per clock unless out_ready holds the output stage:
// a byte waits in the input register, the phase step and byte-wide CRC update
// (poly 0x07, init 0, over sync, instruction, length and payload) run as it
// steps out, and any result goes to the output register and is offered from
// there. Payload bytes give one result each, the CRC byte the frame report
// (accepted, crc mismatch, or heartbeat for instruction 0 / length 0); sync,
// instruction and length bytes give none. sync_value must be written through
// cfg_we/cfg_wdata while the block is idle; the block does not enforce this.
module crc8_frame_receiver_unit import crc8fr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] link_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] instruction,
    output logic [7:0] data_byte,
    output logic [7:0] byte_index,
    output logic [7:0] frame_length
);

    logic [7:0] sync_reg;
    logic       in_full;
    logic [7:0] cur_byte;
    logic       step;
    logic       can_load;
    logic       res_valid;
    result_t    res;
    result_t    res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sync_reg <= SYNC_RESET;
        else if (cfg_we)
            sync_reg <= cfg_wdata;
    end

    assign step = in_full && can_load;

    crc8fr_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .link_byte (link_byte),
        .step      (step),
        .full      (in_full),
        .byte_out  (cur_byte)
    );

    crc8fr_deframer u_deframer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_in    (cur_byte),
        .sync_value (sync_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    crc8fr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res_in    (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (can_load),
        .res_out   (res_out)
    );

    assign kind         = res_out.kind;
    assign instruction  = res_out.instruction;
    assign data_byte    = res_out.data_byte;
    assign byte_index   = res_out.byte_index;
    assign frame_length = res_out.frame_length;

`ifndef SYNTHESIS
    // a held byte must move whenever the result register has room
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full && (!out_valid || out_ready)) |-> step)
        else $error("input byte held although output stage can load");

    a_step_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> in_full)
        else $error("deframer stepped without a byte");

    a_end_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_PAYLOAD) |-> byte_index == 8'd0)
        else $error("frame report with nonzero index");

    a_heartbeat_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_HEARTBEAT) |->
            (instruction == 8'd0 && frame_length == 8'd0))
        else $error("heartbeat report with nonzero header");
`endif

endmodule

// ----- test/tb_crc8_frame_receiver_unit.sv -----
`timescale 1ns / 1ps

module tb_crc8_frame_receiver_unit;
    import crc8fr_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int PLAN_PHASES = 5;
    localparam int BEATS_PER_PHASE = 190;

    typedef struct {
        logic [7:0] value;
        int         gap;
        bit         drain;
    } link_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] link_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] instruction;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;

    // receiver state as the testbench tracks it
    phase_t     rx_phase;
    logic [7:0] sync_cfg;
    logic [7:0] hdr_instr;
    logic [7:0] hdr_len;
    logic [7:0] payload_pos;
    logic [7:0] crc_acc;

    link_beat_t pending_beats[$];
    result_t    frame_reports[$];
    logic [7:0] frame_body[$];

    link_beat_t next_beat;
    result_t    want;
    int         since_beat;
    int         stall_left;
    int         free_left;
    int         quiet_cycles;
    int         fault_count;
    int         stim_count;
    int         beats_taken;
    int         payload_seen;
    int         accepted_seen;
    int         mismatch_seen;
    int         heartbeat_seen;

    crc8_frame_receiver_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .link_byte    (link_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .instruction  (instruction),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .frame_length (frame_length)
    );

    always #5 clk = ~clk;

    // bit-serial form of the x^8 + x^2 + x + 1 update, msb first
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ b[i];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic track_link_byte(input logic [7:0] b);
        result_t r;
        case (rx_phase)
            PH_INSTR:
            begin
                hdr_instr = b;
                crc_acc = crc8_next(crc_acc, b);
                rx_phase = PH_LEN;
            end
            PH_LEN:
            begin
                hdr_len = b;
                crc_acc = crc8_next(crc_acc, b);
                payload_pos = 8'h00;
                rx_phase = (b != 8'h00) ? PH_PAYLOAD : PH_CRC;
            end
            PH_PAYLOAD:
            begin
                crc_acc = crc8_next(crc_acc, b);
                r.kind = KIND_PAYLOAD;
                r.instruction = hdr_instr;
                r.data_byte = b;
                r.byte_index = payload_pos;
                r.frame_length = hdr_len;
                frame_reports.push_back(r);
                payload_pos = payload_pos + 8'd1;
                if (payload_pos == hdr_len)
                    rx_phase = PH_CRC;
            end
            PH_CRC:
            begin
                if (b != crc_acc)
                    r.kind = KIND_MISMATCH;
                else if (hdr_instr == 8'h00 && hdr_len == 8'h00)
                    r.kind = KIND_HEARTBEAT;
                else
                    r.kind = KIND_ACCEPTED;
                r.instruction = hdr_instr;
                r.data_byte = b;
                r.byte_index = 8'h00;
                r.frame_length = hdr_len;
                frame_reports.push_back(r);
                rx_phase = PH_HUNT;
            end
            default:
            begin
                // anything but the sync byte is dropped while hunting
                rx_phase = PH_HUNT;
                if (b == sync_cfg)
                begin
                    crc_acc = crc8_next(8'h00, b);
                    rx_phase = PH_INSTR;
                end
            end
        endcase
    endtask

    task automatic push_beat(input logic [7:0] v, input bit burst, input bit hold);
        link_beat_t nb;
        nb.value = v;
        nb.gap = (burst || $urandom_range(0, 99) < 60) ? 0 : idle_length();
        nb.drain = hold;
        pending_beats.push_back(nb);
        stim_count++;
    endtask

    // sends sync, header and frame_body; the crc byte only if the body is complete
    task automatic queue_frame(input logic [7:0] instr, input int len, input bit good_crc);
        logic [7:0] fcs;
        logic [7:0] flip;
        bit         burst;
        burst = ($urandom_range(0, 99) < 20);
        fcs = crc8_next(8'h00, sync_cfg);
        push_beat(sync_cfg, burst, $urandom_range(0, 99) < 3);
        fcs = crc8_next(fcs, instr);
        push_beat(instr, burst, 1'b0);
        fcs = crc8_next(fcs, len[7:0]);
        push_beat(len[7:0], burst, 1'b0);
        foreach (frame_body[i])
        begin
            fcs = crc8_next(fcs, frame_body[i]);
            push_beat(frame_body[i], burst, 1'b0);
        end
        if (frame_body.size() == len)
        begin
            flip = 8'h01 << $urandom_range(0, 7);
            push_beat(good_crc ? fcs : fcs ^ flip, burst, 1'b0);
        end
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_valid || frame_reports.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            link_byte <= 8'h00;
            since_beat = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_link_byte(link_byte);
                beats_taken++;
            end
            if (in_valid && !in_ready)
                since_beat = 0;
            else if (pending_beats.size() != 0 && since_beat >= pending_beats[0].gap
                     && !(pending_beats[0].drain && frame_reports.size() != 0))
            begin
                next_beat = pending_beats.pop_front();
                in_valid <= 1'b1;
                link_byte <= next_beat.value;
                since_beat = 0;
            end
            else
            begin
                in_valid <= 1'b0;
                since_beat++;
            end
        end
    end

    // receiver side: random backpressure and result check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            free_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frame_reports.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected report: kind %0d instr %h data %h idx %0d len %0d",
                                 kind, instruction, data_byte, byte_index, frame_length);
                end
                else
                begin
                    want = frame_reports.pop_front();
                    if (kind !== want.kind || instruction !== want.instruction
                        || data_byte !== want.data_byte || byte_index !== want.byte_index
                        || frame_length !== want.frame_length)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                        begin
                            $display("report mismatch: expected kind %0d instr %h data %h idx %0d len %0d",
                                     want.kind, want.instruction, want.data_byte,
                                     want.byte_index, want.frame_length);
                            $display("                 got      kind %0d instr %h data %h idx %0d len %0d",
                                     kind, instruction, data_byte, byte_index, frame_length);
                        end
                    end
                    case (want.kind)
                        KIND_PAYLOAD:  payload_seen++;
                        KIND_ACCEPTED: accepted_seen++;
                        KIND_MISMATCH: mismatch_seen++;
                        default:       heartbeat_seen++;
                    endcase
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (free_left != 0)
            begin
                free_left--;
                out_ready <= 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 99)) inside
                    [0:3]:   free_left = $urandom_range(20, 100);
                    [4:29]:  stall_left = idle_length();
                    default: ;
                endcase
                out_ready <= (stall_left == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no beat moved for %0d cycles, %0d reports outstanding",
                     quiet_cycles, frame_reports.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] sync_plan[PLAN_PHASES];
        logic [7:0] instr;
        logic [7:0] v;
        int         len;
        int         pick;
        sync_plan[0] = SYNC_RESET;
        sync_plan[1] = 8'h00;
        sync_plan[2] = 8'hFF;
        sync_plan[3] = 8'($urandom);
        sync_plan[4] = 8'h7E;
        rx_phase = PH_HUNT;
        sync_cfg = SYNC_RESET;
        hdr_instr = 8'h00;
        hdr_len = 8'h00;
        payload_pos = 8'h00;
        crc_acc = 8'h00;
        quiet_cycles = 0;
        fault_count = 0;
        stim_count = 0;
        beats_taken = 0;
        payload_seen = 0;
        accepted_seen = 0;
        mismatch_seen = 0;
        heartbeat_seen = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: hunt noise, heartbeats good and bad, sync byte inside payload,
        // extreme instruction and payload values
        push_beat(8'h00, 1'b0, 1'b0);
        push_beat(8'hFF, 1'b0, 1'b0);
        push_beat(8'h55, 1'b0, 1'b0);
        frame_body.delete();
        queue_frame(8'h00, 0, 1'b1);
        queue_frame(8'h00, 0, 1'b0);
        frame_body.push_back(8'h00);
        frame_body.push_back(SYNC_RESET);
        queue_frame(8'h00, 2, 1'b1);
        frame_body.delete();
        frame_body.push_back(8'hFF);
        queue_frame(8'hFF, 1, 1'b0);

        for (int ph = 0; ph < PLAN_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                wait_idle();
                cfg_we <= 1'b1;
                cfg_wdata <= sync_plan[ph];
                @(posedge clk);
                cfg_we <= 1'b0;
                sync_cfg = sync_plan[ph];
            end
            if (ph == 2)
            begin
                // longest frame, last payload index 254
                frame_body.delete();
                for (int i = 0; i < 255; i++)
                begin
                    v = 8'($urandom);
                    frame_body.push_back(v);
                end
                queue_frame(8'($urandom), 255, 1'b1);
            end
            while (stim_count < (ph + 1) * BEATS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 88 && pick >= 72)
                begin
                    // line noise while hunting, now and then the sync value itself
                    repeat ($urandom_range(1, 4))
                    begin
                        v = 8'($urandom);
                        if (v == sync_cfg && $urandom_range(0, 3) != 0)
                            v = ~v;
                        push_beat(v, 1'b0, 1'b0);
                    end
                end
                else
                begin
                    pick = (pick < 72) ? $urandom_range(0, 99) : -1;
                    if (pick < 0)
                        len = $urandom_range(2, 8);
                    else if (pick < 15)
                        len = 0;
                    else if (pick < 85)
                        len = $urandom_range(1, 6);
                    else if (pick < 97)
                        len = $urandom_range(7, 20);
                    else
                        len = $urandom_range(21, 60);
                    instr = 8'($urandom);
                    if ($urandom_range(0, 99) < ((len == 0) ? 50 : 15))
                        instr = 8'h00;
                    frame_body.delete();
                    // a broken frame stops short and the next frame gets eaten as payload
                    for (int i = 0; i < ((pick < 0) ? $urandom_range(0, len - 1) : len); i++)
                    begin
                        v = ($urandom_range(0, 15) == 0) ? sync_cfg : 8'($urandom);
                        frame_body.push_back(v);
                    end
                    queue_frame(instr, len, $urandom_range(0, 99) < 85);
                end
            end
        end

        wait_idle();
        $display("%0d link beats over %0d sync settings, extremes 0x00 and 0xff included",
                 beats_taken, PLAN_PHASES);
        $display("reports: %0d payload, %0d accepted, %0d crc mismatch, %0d heartbeat",
                 payload_seen, accepted_seen, mismatch_seen, heartbeat_seen);
        if (fault_count == 0 && frame_reports.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/crc8fr_pkg.sv
rtl/crc8fr_in_stage.sv
rtl/crc8fr_deframer.sv
rtl/crc8fr_out_stage.sv
rtl/crc8_frame_receiver_unit.sv
test/tb_crc8_frame_receiver_unit.sv
